/* rtl/lru_stack_distance_miss_counter_assert.svh */
// Assertion macros used by the checker file.
`ifndef LRU_STACK_DISTANCE_MISS_COUNTER_ASSERT_SVH
`define LRU_STACK_DISTANCE_MISS_COUNTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LSD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LSD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/lsdmc_pkg.sv */
// Package with constants and types of the LRU stack distance miss counter.
`default_nettype none
package lsdmc_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int MAX_SIZES   = 7;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int SIZE_W      = 11;
    localparam int SIDX_W      = 3;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_RANGE  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] REG_NUM_SIZES = 3'd0;
    localparam logic [2:0] REG_SIZE_0    = 3'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic rd_start;  // read stack entry at index 0
        logic rd_next;   // advance the search index and read it
        logic wr_shift;  // write held entry one slot down
        logic wr_top;    // write the address at the top
        logic hit_count; // count misses for a hit at current depth
        logic cold;      // count a cold miss and grow the fill
        logic next_addr; // step to the next range address
        logic rep_next;  // advance report index
        logic clr;       // clear all counters
    } t_cmd;

    typedef struct packed {
        logic match;     // registered read data equals address
        logic at_end;    // search index reached fill
        logic more;      // range has another access
        logic rep_last;  // report index is the final active size
        logic rep_none;  // no active sizes
    } t_sts;
endpackage
`default_nettype wire

/* rtl/lsdmc_ram.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none
module lsdmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/lsdmc_datapath.sv */
// Datapath: LRU stack memory, search pointer, counters and config registers.
`default_nettype none
module lsdmc_datapath import lsdmc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [1:0]        i_kind,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [ADDR_W-1:0] i_stride,
    input  wire logic [15:0]       i_count,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    output logic      [31:0]       o_cfg_rdata,
    input  wire logic [2:0]        i_cfg_ridx,
    output logic      [SIDX_W-1:0] o_size_index,
    output logic      [CNT_W-1:0]  o_miss_count,
    output logic                   o_last,
    output logic      [1:0]        o_kind
);
    logic [2:0]        r_num;
    logic [SIZE_W-1:0] r_size [MAX_SIZES];
    logic [CNT_W-1:0]  r_ctr [MAX_SIZES];
    logic [FILL_W-1:0] r_fill;
    logic [ADDR_W-1:0] r_addr, r_stride;
    logic [15:0]       r_left;
    logic [1:0]        r_kind;
    logic [FILL_W-1:0] r_idx;      // index of the entry now read
    logic [ADDR_W-1:0] r_hold;     // entry to push one slot down
    logic [SIDX_W-1:0] r_rep;
    logic [ADDR_W-1:0] w_rdata;
    logic              w_we;
    logic [PTR_W-1:0]  w_waddr;
    logic [PTR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0] w_wdata;
    logic [2:0]        w_act;

    assign w_act = (r_num > 3'(MAX_SIZES)) ? 3'(MAX_SIZES) : r_num;

    // Writes go to idx (shift) or 0 (top); reads to idx, 0 or the next idx.
    always_comb begin
        w_we    = i_cmd.wr_shift || i_cmd.wr_top;
        w_wdata = i_cmd.wr_top ? r_addr : r_hold;
        w_waddr = i_cmd.wr_top ? '0 : r_idx[PTR_W-1:0];
        w_raddr = r_idx[PTR_W-1:0];
        if (i_cmd.rd_start) begin
            w_raddr = '0;
        end else if (i_cmd.rd_next) begin
            w_raddr = PTR_W'(r_idx + 1'b1);
        end
    end

    lsdmc_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(w_wdata), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= 3'd1;
            r_fill <= '0;
            r_idx  <= '0;
            r_rep  <= '0;
            for (int k = 0; k < MAX_SIZES; k++) begin
                r_size[k] <= SIZE_W'(1 << k);
                r_ctr[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_NUM_SIZES) begin
                    r_num <= i_cfg_data[2:0];
                end else begin
                    r_size[i_cfg_idx - REG_SIZE_0] <= i_cfg_data[SIZE_W-1:0];
                end
            end
            if (i_cmd.load) begin
                r_addr   <= i_address;
                r_stride <= i_stride;
                r_left   <= i_count;
                r_kind   <= i_kind;
                r_rep    <= '0;
            end
            if (i_cmd.rd_start) begin
                r_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_idx <= r_idx + 1'b1;
            end
            // Shifting: the entry read now moves down, the old hold goes in.
            if (i_cmd.rd_start) begin
                r_hold <= r_addr;
            end else if (i_cmd.wr_shift) begin
                r_hold <= w_rdata;
            end
            if (i_cmd.next_addr) begin
                r_addr <= r_addr + r_stride;
                r_left <= r_left - 16'd1;
            end
            if (i_cmd.cold && r_fill != FILL_W'(STACK_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.hit_count || i_cmd.cold) begin
                logic go;
                go = 1'b1;
                for (int k = 0; k < MAX_SIZES; k++) begin
                    if (3'(k) < w_act && go) begin
                        if (i_cmd.cold || {1'b0, r_size[k]} < (r_idx + 1'b1)) begin
                            if (r_ctr[k] != '1) r_ctr[k] <= r_ctr[k] + 1'b1;
                        end else begin
                            go = 1'b0;
                        end
                    end
                end
            end
            if (i_cmd.rep_next) begin
                r_rep <= r_rep + 3'd1;
            end
            if (i_cmd.clr) begin
                for (int k = 0; k < MAX_SIZES; k++) r_ctr[k] <= '0;
            end
        end
    end

    always_comb begin
        o_cfg_rdata = '0;
        if (i_cfg_ridx == REG_NUM_SIZES) begin
            o_cfg_rdata = {29'd0, r_num};
        end else begin
            o_cfg_rdata = {21'd0, r_size[i_cfg_ridx - REG_SIZE_0]};
        end
    end

    assign o_sts.match    = (w_rdata == r_addr);
    assign o_sts.at_end   = (r_idx == r_fill);
    assign o_sts.more     = (r_left > 16'd1);
    assign o_sts.rep_last = (r_rep + 3'd1 == w_act);
    assign o_sts.rep_none = (w_act == 3'd0);
    assign o_size_index   = r_rep;
    assign o_miss_count   = r_ctr[r_rep];
    assign o_last         = (r_rep + 3'd1 == w_act);
    assign o_kind         = r_kind;
endmodule
`default_nettype wire

/* rtl/lsdmc_ctrl.sv */
// Controller state machine sequencing searches, stack shifts and reports.
`default_nettype none
module lsdmc_ctrl import lsdmc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [15:0] i_count,
    input  wire logic [1:0] i_hkind,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_valid,
    input  wire logic       i_out_stall
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_SEARCH, S_TOP, S_REPORT} t_state;
    t_state r_state, n_state;
    logic   w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = (r_state == S_REPORT) && !i_sts.rep_none;

    // Search: each cycle compares entry idx (read last cycle) and writes the
    // held entry into slot idx; a match or the fill end stops, then the top
    // is written.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_kind == KIND_SINGLE ||
                        (i_kind == KIND_RANGE && i_count != 16'd0)) begin
                        n_state = S_START;
                    end else if (i_kind == KIND_REPORT) begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_START: begin
                o_cmd.rd_start = 1'b1;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.at_end) begin
                    o_cmd.cold = 1'b1;
                    n_state = S_TOP;
                end else if (i_sts.match) begin
                    o_cmd.hit_count = 1'b1;
                    n_state = S_TOP;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_TOP: begin
                o_cmd.wr_top = 1'b1;
                if (i_hkind == KIND_RANGE && i_sts.more) begin
                    o_cmd.next_addr = 1'b1;
                    n_state = S_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_sts.rep_none) begin
                    o_cmd.clr = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_out_stall) begin
                    o_cmd.rep_next = 1'b1;
                    if (i_sts.rep_last) begin
                        o_cmd.clr = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* rtl/lru_stack_distance_miss_counter.sv */
// Top level of the LRU stack distance miss counter.
// Flow: an accepted access reads stack entry 0 (S_START), then searches and shifts with
// one stack entry per cycle read and written back one slot down (S_SEARCH), then writes the top (S_TOP).
// A new access is taken only in S_IDLE; o_stall stays high until the previous one is done.
// A report gives one transaction per cycle per active size while i_stall is low, then clears.
// Reset is synchronous, active low; the stack needs no clearing pass.
`default_nettype none
module lru_stack_distance_miss_counter import lsdmc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_kind,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [ADDR_W-1:0] i_stride,
    input  wire logic [15:0]       i_count,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [SIDX_W-1:0] o_size_index,
    output logic      [CNT_W-1:0]  o_miss_count,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [1:0] w_hkind;
    logic       w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    lsdmc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_count(i_count), .i_hkind(w_hkind), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_valid(o_valid), .i_out_stall(i_stall)
    );

    lsdmc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind(i_kind), .i_address(i_address), .i_stride(i_stride),
        .i_count(i_count), .i_cfg_we(w_cfg_we), .i_cfg_idx(paddr[4:2]),
        .i_cfg_data(pwdata), .o_cfg_rdata(prdata), .i_cfg_ridx(paddr[4:2]),
        .o_size_index(o_size_index), .o_miss_count(o_miss_count),
        .o_last(o_last), .o_kind(w_hkind)
    );
endmodule
`default_nettype wire

/* rtl/lsdmc_checker.sv */
// Port-level checker for the LRU stack distance miss counter.
`default_nettype none
`include "lru_stack_distance_miss_counter_assert.svh"
module lsdmc_checker import lsdmc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [SIDX_W-1:0] o_size_index,
    input wire logic              o_last,
    input wire logic              pready
);
    `LSD_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `LSD_ASSERT_IMP(a_busy_report, i_clk, i_rst_n, o_valid, o_stall)
    `LSD_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last,
        o_valid && o_size_index == $past(o_size_index) + 3'd1)
    `LSD_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && !i_stall && o_last,
        !o_valid)
endmodule

bind lru_stack_distance_miss_counter lsdmc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_size_index(o_size_index),
    .o_last(o_last), .pready(pready)
);
`default_nettype wire
